[rtl/swbm_pkg.sv]
package swbm_pkg;

    // Command codes on the mode field
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PRES  = 2'd1;
    localparam logic [1:0] ST_STUCK    = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_COUNT     = 8;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam logic [2:0] CFG_RST_LOW    = 3'd0;
    localparam logic [2:0] CFG_PRES_WAIT  = 3'd1;
    localparam logic [2:0] CFG_RST_TAIL   = 3'd2;
    localparam logic [2:0] CFG_ONE_LOW    = 3'd3;
    localparam logic [2:0] CFG_ZERO_LOW   = 3'd4;
    localparam logic [2:0] CFG_RD_LOW     = 3'd5;
    localparam logic [2:0] CFG_RD_SAMPLE  = 3'd6;
    localparam logic [2:0] CFG_RD_TAIL    = 3'd7;

    localparam int unsigned TICK_W = 10;

    typedef logic [TICK_W-1:0] t_ticks;

    // Reset values of the timing registers, in index order
    localparam t_ticks CFG_DEFAULT [CFG_COUNT] = '{
        10'd750, 10'd70, 10'd410, 10'd12, 10'd100, 10'd10, 10'd10, 10'd53
    };

    // Fixed timings
    localparam t_ticks POLL_GAP       = 10'd2;
    localparam t_ticks REC_ONE_TICKS  = 10'd120;
    localparam t_ticks REC_ZERO_TICKS = 10'd30;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_in;
        logic       line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
    } t_out_item;

endpackage

[rtl/single_wire_bus_master_unit.sv]
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_ready  i_in_data  (swbm_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (swbm_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One input item is one bus tick; it is handled by the combinational phase
// sequencer and its result lands in the output register the same edge.
// Throughput is one item per cycle unless the output stalls; the output register is the only stage.
// Synchronous active-low reset returns the sequencer to idle and the timing
// registers to their defaults. A stalled output holds the input off only
// while the output register is full and not being taken.
module single_wire_bus_master_unit #(
    parameter int unsigned IDLE_POLLS = 125
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  swbm_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output swbm_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [swbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [swbm_pkg::TICK_W-1:0]          i_cfg_data
);

    localparam logic [7:0] POLL_LIMIT = 8'(IDLE_POLLS - 1);

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_POLL     = 10'b00_0000_0010,
        PH_RST_LOW  = 10'b00_0000_0100,
        PH_RST_WAIT = 10'b00_0000_1000,
        PH_RST_TAIL = 10'b00_0001_0000,
        PH_WR_LOW   = 10'b00_0010_0000,
        PH_WR_REC   = 10'b00_0100_0000,
        PH_RD_LOW   = 10'b00_1000_0000,
        PH_RD_WAIT  = 10'b01_0000_0000,
        PH_RD_TAIL  = 10'b10_0000_0000
    } t_phase;

    swbm_pkg::t_ticks r_cfg [swbm_pkg::CFG_COUNT];

    t_phase           r_phase, n_phase;
    swbm_pkg::t_ticks r_tick, n_tick;
    logic [2:0]       r_bit_idx, n_bit_idx;
    logic [7:0]       r_shift, n_shift;
    logic [7:0]       r_poll, n_poll;
    logic [1:0]       r_status, n_status;
    logic [7:0]       r_rd_data, n_rd_data;
    logic             n_done;

    logic                r_out_valid;
    swbm_pkg::t_out_item r_out;

    logic             in_acc;
    swbm_pkg::t_ticks tick_inc;
    swbm_pkg::t_ticks limit;
    logic             expired;
    logic             wr_bit;
    logic [7:0]       rd_shift;
    logic [7:0]       poll_inc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < swbm_pkg::CFG_COUNT; i++) begin
                r_cfg[i] <= swbm_pkg::CFG_DEFAULT[i];
            end
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Expiry limit of the current phase
    always_comb begin
        wr_bit = r_shift[0];
        case (r_phase)
            PH_POLL:     limit = swbm_pkg::POLL_GAP;
            PH_RST_LOW:  limit = r_cfg[swbm_pkg::CFG_RST_LOW];
            PH_RST_WAIT: limit = r_cfg[swbm_pkg::CFG_PRES_WAIT];
            PH_RST_TAIL: limit = r_cfg[swbm_pkg::CFG_RST_TAIL];
            PH_WR_LOW:   limit = wr_bit ? r_cfg[swbm_pkg::CFG_ONE_LOW]
                                        : r_cfg[swbm_pkg::CFG_ZERO_LOW];
            PH_WR_REC:   limit = wr_bit ? swbm_pkg::REC_ONE_TICKS
                                        : swbm_pkg::REC_ZERO_TICKS;
            PH_RD_LOW:   limit = r_cfg[swbm_pkg::CFG_RD_LOW];
            PH_RD_WAIT:  limit = r_cfg[swbm_pkg::CFG_RD_SAMPLE];
            PH_RD_TAIL:  limit = r_cfg[swbm_pkg::CFG_RD_TAIL];
            default:     limit = '0;
        endcase
        tick_inc = r_tick + 1'b1;
        expired  = (tick_inc >= limit);
        rd_shift = {i_in_data.line_level, r_shift[7:1]};
        poll_inc = r_poll + 1'b1;
    end

    // Phase sequencer: next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_tick    = tick_inc;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_poll    = r_poll;
        n_status  = r_status;
        n_rd_data = r_rd_data;
        n_done    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                n_tick = r_tick;
                case (i_in_data.mode)
                    swbm_pkg::MODE_RESET: begin
                        n_poll  = '0;
                        n_phase = PH_POLL;
                        n_tick  = '0;
                    end
                    swbm_pkg::MODE_WRITE: begin
                        n_shift   = i_in_data.data_in;
                        n_bit_idx = '0;
                        n_phase   = PH_WR_LOW;
                        n_tick    = '0;
                    end
                    swbm_pkg::MODE_READ: begin
                        n_shift   = '0;
                        n_bit_idx = '0;
                        n_phase   = PH_RD_LOW;
                        n_tick    = '0;
                    end
                    default: ;
                endcase
            end
            PH_POLL: begin
                if (expired) begin
                    n_tick = '0;
                    n_poll = poll_inc;
                    if (i_in_data.line_level) begin
                        n_phase = PH_RST_LOW;
                    end else if (poll_inc >= POLL_LIMIT) begin
                        n_phase  = PH_IDLE;
                        n_status = swbm_pkg::ST_STUCK;
                        n_done   = 1'b1;
                    end
                end
            end
            PH_RST_LOW: begin
                if (expired) begin
                    n_phase = PH_RST_WAIT;
                    n_tick  = '0;
                end
            end
            PH_RST_WAIT: begin
                if (expired) begin
                    n_tick   = '0;
                    n_status = i_in_data.line_level ? swbm_pkg::ST_NO_PRES
                                                    : swbm_pkg::ST_OK;
                    if (r_cfg[swbm_pkg::CFG_RST_TAIL] == '0) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = PH_RST_TAIL;
                    end
                end
            end
            PH_RST_TAIL: begin
                if (expired) begin
                    n_tick  = '0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            PH_WR_LOW: begin
                if (expired) begin
                    n_phase = PH_WR_REC;
                    n_tick  = '0;
                end
            end
            PH_WR_REC: begin
                if (expired) begin
                    n_tick = '0;
                    if (r_bit_idx == 3'd7) begin
                        n_phase  = PH_IDLE;
                        n_status = swbm_pkg::ST_OK;
                        n_done   = 1'b1;
                    end else begin
                        n_shift   = {1'b0, r_shift[7:1]};
                        n_bit_idx = r_bit_idx + 1'b1;
                        n_phase   = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW: begin
                if (expired) begin
                    n_phase = PH_RD_WAIT;
                    n_tick  = '0;
                end
            end
            PH_RD_WAIT, PH_RD_TAIL: begin
                if (expired) begin
                    n_tick = '0;
                    if (r_phase == PH_RD_WAIT) begin
                        n_shift = rd_shift;
                    end
                    // a zero tail advances on the sample tick itself
                    if (r_phase == PH_RD_WAIT && r_cfg[swbm_pkg::CFG_RD_TAIL] != '0) begin
                        n_phase = PH_RD_TAIL;
                    end else if (r_bit_idx == 3'd7) begin
                        n_rd_data = (r_phase == PH_RD_WAIT) ? rd_shift : r_shift;
                        n_phase   = PH_IDLE;
                        n_status  = swbm_pkg::ST_OK;
                        n_done    = 1'b1;
                    end else begin
                        n_bit_idx = r_bit_idx + 1'b1;
                        n_phase   = PH_RD_LOW;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_poll    <= '0;
            r_status  <= swbm_pkg::ST_OK;
            r_rd_data <= '0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_poll    <= n_poll;
            r_status  <= n_status;
            r_rd_data <= n_rd_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.drive_low <= (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW)
                               || (n_phase == PH_RD_LOW);
            r_out.busy_res  <= (n_phase != PH_IDLE);
            r_out.done_res  <= n_done;
            r_out.status    <= n_status;
            r_out.read_data <= n_rd_data;
        end
    end

endmodule

[rtl/swbm_checker.sv]
module swbm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input swbm_pkg::t_in_item                   i_in_data,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input swbm_pkg::t_out_item                  o_out_data,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready,
    input logic [swbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [swbm_pkg::TICK_W-1:0]          i_cfg_data
);

    // A completing item is never also busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.done_res && o_out_data.busy_res))
        else $error("done and busy together");

    // The line is only pulled low inside a command
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.drive_low) |-> o_out_data.busy_res)
        else $error("drive low while not busy");

    // An empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Status code is always meaningful
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == swbm_pkg::ST_OK
                         || o_out_data.status == swbm_pkg::ST_NO_PRES
                         || o_out_data.status == swbm_pkg::ST_STUCK))
        else $error("bad status code");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind single_wire_bus_master_unit swbm_checker u_swbm_checker (.*);
